/* rtl/core/wbps_pkg.sv */
`default_nettype none

package wbps_pkg;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SCAN  = 2'd1,
        CMD_BEGIN = 2'd2
    } t_cmd;

    // Register select, taken from the word address on the configuration port.
    typedef enum logic {
        REG_PATTERN_LENGTH = 1'b0,
        REG_REGION_BASE    = 1'b1
    } t_reg;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 64;
    localparam int LEN_REG_W = 6;

    localparam logic [7:0]           WILDCARD_BYTE = 8'h3F;
    localparam logic [LEN_REG_W-1:0] LENGTH_RESET  = 6'd1;

    // One input item.
    typedef struct packed {
        t_cmd       command;
        logic [4:0] pattern_index;
        logic [7:0] pattern_char;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // One result item.
    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
        logic [63:0] match_address;
    } t_out;

endpackage

`default_nettype wire

/* rtl/core/wildcard_byte_pattern_scanner.sv */
// A scan byte accepted at the input is held in the compare stage, and a result
// it produces is then loaded into the output register that drives o_out_valid.
// Throughput: one item per cycle; the input stalls only while a new result waits
// for a full output register that is not being drained.
// Reset (synchronous, active low) clears the byte window, byte count, scan state,
// registers and output valid; the pattern store is not cleared.
`default_nettype none

module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_MAX = 32,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire wbps_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output wbps_pkg::t_out                         o_out_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wbps_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [wbps_pkg::DATA_W-1:0]       pwdata,
    output logic      [wbps_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam int CLAMP_W = (LEN_W > wbps_pkg::LEN_REG_W) ? LEN_W : wbps_pkg::LEN_REG_W;
    localparam int CMP_W   = OFFSET_BITS + 1;
    localparam int WIN_W   = 8 * PATTERN_MAX;

    // Configuration registers.
    logic [wbps_pkg::LEN_REG_W-1:0] r_pattern_length;
    logic [63:0]                    r_region_base;

    // Pattern store and the sliding byte window (entry 0 is the newest byte).
    logic [7:0] r_pat     [PATTERN_MAX];
    logic [7:0] n_pat     [PATTERN_MAX];
    logic [7:0] r_window  [PATTERN_MAX];
    logic [7:0] n_window  [PATTERN_MAX];

    logic [OFFSET_BITS-1:0] r_bytes_seen, n_bytes_seen;
    logic                   r_done, n_done;

    // Compare stage: a scan byte waiting to be checked against the window.
    logic r_s1_valid, n_s1_valid;
    logic r_s1_last, n_s1_last;

    // Output register.
    logic           r_out_valid, n_out_valid;
    wbps_pkg::t_out r_out, n_out;

    logic                   in_fire;
    logic                   out_free;
    logic                   s2_emit;
    logic                   s2_load;
    logic                   stall;
    logic [CLAMP_W-1:0]     len_raw;
    logic [CLAMP_W-1:0]     len_c;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       shift_amt;
    logic [WIN_W-1:0]       win_vec;
    logic [WIN_W-1:0]       aligned;
    logic [PATTERN_MAX-1:0] pat_ok;
    logic                   enough;
    logic                   found;
    logic [OFFSET_BITS-1:0] off;
    logic                   cfg_write;

    // Active pattern length, clamped to 1..PATTERN_MAX.
    always_comb begin
        len_raw = CLAMP_W'(r_pattern_length);
        if (len_raw == '0) begin
            len_c = CLAMP_W'(1);
        end else if (len_raw > CLAMP_W'(PATTERN_MAX)) begin
            len_c = CLAMP_W'(PATTERN_MAX);
        end else begin
            len_c = len_raw;
        end
        len_eff   = LEN_W'(len_c);
        shift_amt = LEN_W'(PATTERN_MAX) - len_eff;
    end

    // Lay the window out oldest byte first, then shift so that the byte lined up
    // with pattern position 0 lands in the lowest byte lane.
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            win_vec[8*k +: 8] = r_window[PATTERN_MAX-1-k];
        end
        aligned = win_vec >> {shift_amt, 3'b000};
    end

    // Parallel compare of every pattern position; positions past the length pass.
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pat_ok[i] = (i >= int'(len_eff))
                     || (r_pat[i] == wbps_pkg::WILDCARD_BYTE)
                     || (r_pat[i] == aligned[8*i +: 8]);
        end
    end

    assign enough = CMP_W'(r_bytes_seen) >= CMP_W'(len_eff);
    assign found  = enough && (&pat_ok);
    assign off    = r_bytes_seen - OFFSET_BITS'(len_eff);

    // Handshake and flow control.
    assign s2_emit    = r_s1_valid && !r_done && (found || r_s1_last);
    assign out_free   = !r_out_valid || i_out_ready;
    assign stall      = s2_emit && !out_free;
    assign s2_load    = s2_emit && out_free;
    assign o_in_ready = !stall;
    assign in_fire    = i_in_valid && o_in_ready;

    // Result payload: a miss reports zero offset and address.
    always_comb begin
        n_out.found         = found;
        n_out.match_offset  = found ? 32'(off) : '0;
        n_out.match_address = found ? (r_region_base + 64'(off)) : '0;
    end

    // Next state of the scan datapath.
    always_comb begin
        n_pat        = r_pat;
        n_window     = r_window;
        n_bytes_seen = r_bytes_seen;
        n_done       = r_done;
        n_s1_valid   = r_s1_valid;
        n_s1_last    = r_s1_last;

        if (s2_load) begin
            n_done = 1'b1;
        end
        if (!stall) begin
            n_s1_valid = 1'b0;
        end

        if (in_fire) begin
            case (i_in_data.command)
                wbps_pkg::CMD_LOAD: begin
                    for (int k = 0; k < PATTERN_MAX; k++) begin
                        if (32'(i_in_data.pattern_index) == k) begin
                            n_pat[k] = i_in_data.pattern_char;
                        end
                    end
                end
                wbps_pkg::CMD_SCAN: begin
                    n_window[0] = i_in_data.data_byte;
                    for (int k = 1; k < PATTERN_MAX; k++) begin
                        n_window[k] = r_window[k-1];
                    end
                    if (r_bytes_seen != '1) begin
                        n_bytes_seen = r_bytes_seen + OFFSET_BITS'(1);
                    end
                    n_s1_valid = 1'b1;
                    n_s1_last  = i_in_data.last_byte;
                end
                wbps_pkg::CMD_BEGIN: begin
                    for (int k = 0; k < PATTERN_MAX; k++) begin
                        n_window[k] = '0;
                    end
                    n_bytes_seen = '0;
                    n_done       = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid holds until the transfer completes.
    always_comb begin
        if (s2_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state and window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_window[k] <= '0;
            end
            r_bytes_seen <= '0;
            r_done       <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s1_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_window     <= n_window;
            r_bytes_seen <= n_bytes_seen;
            r_done       <= n_done;
            r_s1_valid   <= n_s1_valid;
            r_s1_last    <= n_s1_last;
            r_out_valid  <= n_out_valid;
        end
    end

    // Pattern store and result payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        if (s2_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration port: zero wait states, register picked by the word address.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= wbps_pkg::LENGTH_RESET;
            r_region_base    <= '0;
        end else if (cfg_write) begin
            case (wbps_pkg::t_reg'(paddr[wbps_pkg::ADDR_W-1]))
                wbps_pkg::REG_PATTERN_LENGTH: begin
                    r_pattern_length <= pwdata[wbps_pkg::LEN_REG_W-1:0];
                end
                wbps_pkg::REG_REGION_BASE: begin
                    r_region_base <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (wbps_pkg::t_reg'(paddr[wbps_pkg::ADDR_W-1]))
            wbps_pkg::REG_PATTERN_LENGTH: prdata = wbps_pkg::DATA_W'(r_pattern_length);
            wbps_pkg::REG_REGION_BASE:    prdata = r_region_base;
            default:                      prdata = '0;
        endcase
    end

    // A begin transfer restarts the scan whatever the compare stage did.
    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_data.command == wbps_pkg::CMD_BEGIN)
        |=> (r_bytes_seen == '0) && !r_done)
        else $error("begin did not clear the scan state");

    // A not-found result carries zero offset and address.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found
        |-> (o_out_data.match_offset == '0) && (o_out_data.match_address == '0))
        else $error("not-found result with nonzero offset or address");

    // A new result comes only from a scan byte held in the compare stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a pending scan byte");

    // After the scan has answered, nothing more is produced until a begin.
    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !(in_fire && (i_in_data.command == wbps_pkg::CMD_BEGIN))
        |=> !s2_load)
        else $error("second result in one scan");

endmodule

`default_nettype wire
